FILE: design/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types, constants and the output permutation of the PCG generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcg_pkg;

	localparam logic [63:0] LCG_MULT     = 64'd6364136223846793005;
	localparam logic [63:0] DEFAULT_INCR = 64'd1442695040888963407;
	localparam int          FRAC_SHIFT   = 11;
	localparam int          DIV_STEPS    = 64;
	localparam int          DIV_CNT_W    = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		CMD_RESEED  = 2'd0,
		CMD_RAW     = 2'd1,
		CMD_FRAC    = 2'd2,
		CMD_BOUNDED = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_P0,
		MUL_P1,
		MUL_P2,
		MUL_P3
	} mul_op_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_RAW,
		RES_FRAC,
		RES_MOD
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESEED_INIT,
		ST_ADD_SEED,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_BCHK,
		ST_THR_LOAD,
		ST_THR_DIV,
		ST_THR_SAVE,
		ST_MOD_LOAD,
		ST_MOD_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic     cap_in;
		logic     reseed_init;
		logic     add_seed;
		mul_op_t  mul_op;
		logic     div_load_thr;
		logic     div_load_draw;
		logic     div_step;
		logic     thr_save;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic bound_bad;
		logic div_last;
		logic draw_ge_thr;
	} dp_sts_t;

	// xorshift then variable rotate, all in 64-bit arithmetic
	function automatic logic [63:0] pcg_perm(input logic [63:0] s);
		logic [63:0] x;
		logic [4:0]  rot;
		logic [4:0]  lrot;
		x    = ((s >> 18) ^ s) >> 27;
		rot  = s[63:59];
		lrot = 5'd0 - rot;
		return (x >> rot) | (x << lrot);
	endfunction

endpackage

`default_nettype wire

FILE: design/pcg_datapath.sv
// ----------------------------------------------------------------------------
// pcg_datapath
// LCG state, shared 32x32 multiplier, bit-serial remainder unit and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_datapath import pcg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic        [63:0] seed,
	input  wire logic signed [31:0] bound,
	input  wire dp_cmd_t            cmd,
	output dp_sts_t                 sts,
	output logic             [63:0] value
);

	logic        [63:0] seed_q;
	logic        [63:0] state_q;
	logic        [63:0] incr_q;
	logic        [63:0] draw_q;
	logic        [63:0] pp_q;
	logic        [63:0] acc_q;
	logic signed [31:0] bound_q;
	logic        [63:0] dvd_q;
	logic        [30:0] rem_q;
	logic        [30:0] thr_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic        [63:0] value_q;

	logic        [31:0] mul_a;
	logic        [31:0] mul_b;
	logic        [63:0] mul_p;
	logic        [30:0] m;
	logic        [31:0] trial;
	logic               trial_ge;
	logic        [63:0] res_d;

	assign m = bound_q[30:0];

	always_comb begin
		mul_a = state_q[31:0];
		mul_b = LCG_MULT[31:0];
		case (cmd.mul_op)
			MUL_P1: begin
				mul_a = state_q[63:32];
			end
			MUL_P2: begin
				mul_b = LCG_MULT[63:32];
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// restoring remainder step, one dividend bit per cycle
	assign trial    = {rem_q, dvd_q[63]};
	assign trial_ge = trial >= {1'b0, m};

	always_comb begin
		case (cmd.res_sel)
			RES_RAW:  res_d = draw_q;
			RES_FRAC: res_d = draw_q >> FRAC_SHIFT;
			RES_MOD:  res_d = {33'd0, rem_q};
			default:  res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			state_q <= '0;
			incr_q  <= DEFAULT_INCR;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= seed;
			end
			if (cmd.reseed_init) begin
				state_q <= '0;
				incr_q  <= {seed_q[62:0], 1'b1};
			end else if (cmd.add_seed) begin
				state_q <= state_q + seed_q;
			end else if (cmd.mul_op == MUL_P3) begin
				state_q <= acc_q + {pp_q[31:0], 32'd0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			bound_q <= bound;
		end
		case (cmd.mul_op)
			MUL_P0: begin
				pp_q   <= mul_p;
				draw_q <= pcg_perm(state_q);
			end
			MUL_P1: begin
				acc_q <= pp_q + incr_q;
				pp_q  <= mul_p;
			end
			MUL_P2: begin
				acc_q <= acc_q + {pp_q[31:0], 32'd0};
				pp_q  <= mul_p;
			end
			default: begin
			end
		endcase
		if (cmd.div_load_thr) begin
			dvd_q     <= 64'd0 - {33'd0, m};
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_load_draw) begin
			dvd_q     <= draw_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q     <= dvd_q << 1;
			rem_q     <= trial_ge ? 31'(trial - {1'b0, m}) : trial[30:0];
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
		if (cmd.thr_save) begin
			thr_q <= rem_q;
		end
		if (cmd.out_load) begin
			value_q <= res_d;
		end
	end

	assign sts.bound_bad   = bound_q[31] || (bound_q == '0);
	assign sts.div_last    = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign sts.draw_ge_thr = draw_q >= {33'd0, thr_q};
	assign value           = value_q;

endmodule

`default_nettype wire

FILE: design/pcg_ctrl.sv
// ----------------------------------------------------------------------------
// pcg_ctrl
// Command sequencer: draw phases, reseed passes, rejection loop and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_ctrl import pcg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] command,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire dp_sts_t    sts,
	output dp_cmd_t         cmd
);

	state_t   state_q;
	state_t   state_d;
	command_t cmd_q;
	logic     pass_q;
	logic     out_valid_q;
	logic     out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (command_t'(command))
						CMD_RESEED:  state_d = ST_RESEED_INIT;
						CMD_BOUNDED: state_d = ST_BCHK;
						default:     state_d = ST_MUL0;
					endcase
				end
			end
			ST_RESEED_INIT: state_d = ST_MUL0;
			ST_ADD_SEED:    state_d = ST_MUL0;
			ST_MUL0:        state_d = ST_MUL1;
			ST_MUL1:        state_d = ST_MUL2;
			ST_MUL2:        state_d = ST_MUL3;
			ST_MUL3: begin
				case (cmd_q)
					CMD_RESEED:  state_d = pass_q ? ST_FINISH : ST_ADD_SEED;
					CMD_BOUNDED: state_d = sts.draw_ge_thr ? ST_MOD_LOAD : ST_MUL0;
					default:     state_d = ST_FINISH;
				endcase
			end
			ST_BCHK:     state_d = sts.bound_bad ? ST_FINISH : ST_THR_LOAD;
			ST_THR_LOAD: state_d = ST_THR_DIV;
			ST_THR_DIV: begin
				if (sts.div_last) begin
					state_d = ST_THR_SAVE;
				end
			end
			ST_THR_SAVE: state_d = ST_MUL0;
			ST_MOD_LOAD: state_d = ST_MOD_DIV;
			ST_MOD_DIV: begin
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_op   = MUL_NONE;
		cmd.res_sel  = RES_ZERO;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.cap_in = in_valid;
			end
			ST_RESEED_INIT: cmd.reseed_init   = 1'b1;
			ST_ADD_SEED:    cmd.add_seed      = 1'b1;
			ST_MUL0:        cmd.mul_op        = MUL_P0;
			ST_MUL1:        cmd.mul_op        = MUL_P1;
			ST_MUL2:        cmd.mul_op        = MUL_P2;
			ST_MUL3:        cmd.mul_op        = MUL_P3;
			ST_THR_LOAD:    cmd.div_load_thr  = 1'b1;
			ST_THR_DIV:     cmd.div_step      = 1'b1;
			ST_THR_SAVE:    cmd.thr_save      = 1'b1;
			ST_MOD_LOAD:    cmd.div_load_draw = 1'b1;
			ST_MOD_DIV:     cmd.div_step      = 1'b1;
			ST_FINISH: begin
				cmd.out_load = out_free;
				case (cmd_q)
					CMD_RAW:     cmd.res_sel = RES_RAW;
					CMD_FRAC:    cmd.res_sel = RES_FRAC;
					CMD_BOUNDED: cmd.res_sel = sts.bound_bad ? RES_ZERO : RES_MOD;
					default:     cmd.res_sel = RES_ZERO;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_RESEED;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.cap_in) begin
				cmd_q  <= command_t'(command);
				pass_q <= 1'b0;
			end else if (state_q == ST_ADD_SEED) begin
				pass_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_rose_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result became valid outside finish");

	a_div_step_states: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (state_q == ST_THR_DIV || state_q == ST_MOD_DIV))
		else $error("remainder step outside division states");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("transfer accepted but sequencer stayed idle");

	a_mod_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD_DIV && state_d == ST_FINISH) |-> sts.div_last)
		else $error("remainder left before all dividend bits");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.out_load)
		else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

FILE: design/pcg_random_generator.sv
// ----------------------------------------------------------------------------
// pcg_random_generator
// PCG-style generator: 64-bit LCG with a 64-bit XSH-RR style output.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_stall) carries command and bound; a transfer
//   happens when in_valid is high and in_stall low. One item is worked on at
//   a time; in_stall is low only while the sequencer is idle.
//   output channel (out_valid/out_stall) returns one value per item from an
//   output register, so the next item is taken while a result still waits.
//   seed is written over cfg_valid/cfg_ready (always ready); the user must
//   write it only while idle, which the block itself does not enforce.
// Per item, on the shared 32x32 multiplier and the bit-serial remainder unit:
//   a raw or fraction draw is an LCG step; a reseed is an init, an LCG step,
//   a seed add and an LCG step; a bounded draw is a threshold pass, an LCG
//   step per draw tried and a remainder pass; a bound <= 0 skips all of it.
// Reset clears the state to 0, the increment to its default and the seed
//   to 0. A stalled result holds; a finished item then waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_random_generator import pcg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [1:0]  command,
	input  wire logic signed [31:0] bound,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [63:0] value,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [63:0] seed
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	assign cfg_ready = 1'b1;

	pcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	pcg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.seed      (seed),
		.bound     (bound),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.value     (value)
	);

endmodule

`default_nettype wire

FILE: tb/sv/pcg_checker.sv
// ----------------------------------------------------------------------------
// pcg_checker
// Watches the seed, command and result channels of the PCG generator, keeps
// its own copy of the LCG state, stream increment and seed, predicts the value
// of every accepted command and compares it with each returned value in order.
// ----------------------------------------------------------------------------

module pcg_checker import pcg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic        [1:0]  command,
	input  wire logic signed [31:0] bound,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic        [63:0] value,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic        [63:0] seed,
	output int                      mismatch_count,
	output int                      pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0] seed_copy;
	logic [63:0] lcg_copy;
	logic [63:0] incr_copy;
	logic [63:0] expected_values[$];
	logic [63:0] oldest;

	// one LCG step, returns the permuted old state
	function automatic logic [63:0] next_draw();
		logic [63:0] s;
		logic [63:0] x;
		logic [4:0]  rot;
		logic [4:0]  lrot;
		s        = lcg_copy;
		lcg_copy = s * LCG_MULT + incr_copy;
		x        = ((s >> 18) ^ s) >> 27;
		rot      = s[63:59];
		lrot     = 5'd0 - rot;
		return (x >> rot) | (x << lrot);
	endfunction

	function automatic logic [63:0] predict_value(input logic [1:0] cmd,
			input logic [31:0] bnd);
		logic [63:0] m;
		logic [63:0] thr;
		logic [63:0] r;
		logic [63:0] res;
		res = '0;
		case (cmd)
			CMD_RESEED: begin
				lcg_copy  = '0;
				incr_copy = {seed_copy[62:0], 1'b1};
				r         = next_draw();
				lcg_copy  = lcg_copy + seed_copy;
				r         = next_draw();
			end
			CMD_RAW: begin
				res = next_draw();
			end
			CMD_FRAC: begin
				res = next_draw() >> FRAC_SHIFT;
			end
			default: begin
				// bound of zero or below leaves the state alone
				if (!bnd[31] && bnd != 32'd0) begin
					m   = {32'd0, bnd};
					thr = (64'd0 - m) % m;
					r   = next_draw();
					while (r < thr)
						r = next_draw();
					res = r % m;
				end
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_copy      = '0;
			lcg_copy       = '0;
			incr_copy      = DEFAULT_INCR;
			mismatch_count = 0;
			expected_values.delete();
			pending_count  = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				seed_copy = seed;
			if (in_valid && !in_stall)
				expected_values.push_back(predict_value(command, bound));
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: value %h returned with no command waiting", $realtime,
							value);
					mismatch_count++;
				end else begin
					oldest = expected_values.pop_front();
					if (value !== oldest) begin
						if (mismatch_count < 10)
							$display("%0t: value expected %h actual %h", $realtime, oldest,
								value);
						mismatch_count++;
					end
				end
			end
			pending_count = expected_values.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the PCG generator: a directed pass over the command set, bound
// extremes and seed extremes, then random phases that each write a seed,
// mostly reseed and issue random draws, with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pcg_pkg::*;

	localparam int ITEM_TARGET  = 700;
	localparam int CALM_ITEMS   = 100;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 150;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic        [1:0]  command;
	logic signed [31:0] bound;
	logic               out_valid;
	logic               out_stall;
	logic        [63:0] value;
	logic               cfg_valid;
	logic               cfg_ready;
	logic        [63:0] seed;

	int mismatch_count;
	int pending_count;
	int items_sent;
	int idle_cycles;
	bit calm;

	pcg_random_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.bound     (bound),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.seed      (seed)
	);

	pcg_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.bound          (bound),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.seed           (seed),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input command_t cmd, input logic [31:0] bnd);
		if (!calm && $urandom_range(0, 2) == 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		@(negedge clk);
		command  <= cmd;
		bound    <= bnd;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// seed is only written once every result is back
	task automatic write_seed(input logic [63:0] v);
		@(negedge clk) in_valid <= 1'b0;
		wait (pending_count == 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		seed      <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	function automatic command_t pick_command();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return CMD_RESEED;
		else if (sel < 38)
			return CMD_RAW;
		else if (sel < 62)
			return CMD_FRAC;
		return CMD_BOUNDED;
	endfunction

	function automatic logic [31:0] pick_bound();
		int          sel;
		logic [31:0] b;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			// positive, spread over magnitudes
			b = $urandom() & 32'h7fff_ffff;
			b = b >> $urandom_range(0, 30);
			if (b == 32'd0)
				b = 32'd1;
		end else if (sel < 65) begin
			case ($urandom_range(0, 3))
				0: b = 32'd1;
				1: b = 32'h7fff_ffff;
				2: b = 32'd2;
				default: b = 32'h8000_0000;
			endcase
		end else if (sel < 80) begin
			b = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom() | 32'h8000_0000);
		end else begin
			b = $urandom();
		end
		return b;
	endfunction

	function automatic logic [63:0] seed_for_phase(input int p);
		case (p % 5)
			0: return 64'd0;
			1: return '1;
			2: return {$urandom(), $urandom()};
			3: return 64'd1;
			default: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
		endcase
	endfunction

	initial begin : receiver
		int n;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (calm) begin
				@(negedge clk) out_stall <= 1'b0;
			end else begin
				n = $urandom_range(1, 7);
				@(negedge clk) out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 7);
				@(negedge clk) out_stall <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		int len;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_RESEED;
		bound      = '0;
		cfg_valid  = 1'b0;
		seed       = '0;
		calm       = 1'b0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// draws from the reset state, then every bound corner
		send_item(CMD_RAW, 32'h0);
		send_item(CMD_FRAC, 32'hffff_ffff);
		send_item(CMD_BOUNDED, 32'd1);
		send_item(CMD_BOUNDED, 32'd0);
		send_item(CMD_BOUNDED, 32'hffff_ffff);
		send_item(CMD_BOUNDED, 32'h8000_0000);
		send_item(CMD_BOUNDED, 32'h7fff_ffff);
		send_item(CMD_RESEED, 32'h5555_5555);
		send_item(CMD_RAW, 32'haaaa_aaaa);

		write_seed('1);
		send_item(CMD_RESEED, 32'd0);
		send_item(CMD_RAW, 32'd0);
		send_item(CMD_FRAC, 32'd0);
		send_item(CMD_BOUNDED, 32'd7);
		send_item(CMD_BOUNDED, 32'h7fff_ffff);
		send_item(CMD_BOUNDED, 32'h4000_0001);

		write_seed(64'h8000_0000_0000_0000);
		send_item(CMD_RESEED, 32'hffff_ffff);
		send_item(CMD_BOUNDED, 32'd2);
		send_item(CMD_BOUNDED, 32'd3);
		send_item(CMD_RAW, 32'hffff_ffff);
		send_item(CMD_FRAC, 32'h8000_0000);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			write_seed(seed_for_phase(phase));
			if ($urandom_range(0, 9) != 0)
				send_item(CMD_RESEED, $urandom());
			len = $urandom_range(10, 50);
			repeat (len) begin
				if (items_sent >= ITEM_TARGET - CALM_ITEMS)
					calm = 1'b1;
				send_item(pick_command(), pick_bound());
			end
			phase++;
		end

		@(negedge clk) in_valid <= 1'b0;
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
